[rtl/slm_pkg.sv]
// ----------------------------------------------------------------------------
// Sensor level monitor package
// Shared codes, reset values and helpers for the sensor level monitor.
// ----------------------------------------------------------------------------
package slm_pkg;

   localparam int WINDOW_DEF = 150;

   localparam int SAMPLE_W = 12;
   localparam int MODE_W   = 3;
   localparam int ACTION_W = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int DWELL_W  = 16;
   localparam int OFFSET_W = 13;
   localparam int TIME_W   = 32;

   // item kinds
   localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_BUTTON = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd2;

   // filter modes
   localparam logic [1:0] FILT_RAW    = 2'd0;
   localparam logic [1:0] FILT_AVG    = 2'd1;
   localparam logic [1:0] FILT_OFFSET = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WARN_LEVEL   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ERROR_LEVEL  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DWELL_MS     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_OFFSET = 3'd4;

   // register reset values
   localparam logic [1:0]          FILTER_MODE_RST  = FILT_OFFSET;
   localparam logic [SAMPLE_W-1:0] WARN_LEVEL_RST   = 12'd2000;
   localparam logic [SAMPLE_W-1:0] ERROR_LEVEL_RST  = 12'd3000;
   localparam logic [DWELL_W-1:0]  DWELL_MS_RST     = 16'd5000;
   localparam logic [OFFSET_W-1:0] NOISE_OFFSET_RST = 13'd80;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'd4095;

   // reported mode codes
   localparam logic [MODE_W-1:0] MODE_WAIT   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_LISTEN = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PAUSE  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_WARN   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_ERROR  = 3'd4;

   // value * 3300 / 4095 == (value * MV_MUL) >> MV_SHIFT for all 12-bit values
   localparam int MV_MUL_W  = 21;
   localparam int MV_SHIFT  = 21;
   localparam int MV_PROD_W = SAMPLE_W + MV_MUL_W;
   localparam logic [MV_MUL_W-1:0] MV_MUL = 21'd1690013;
   localparam logic [SAMPLE_W-1:0] MV_MAX = 12'd3300;

   typedef enum logic [4:0] {
      ST_WAIT   = 5'b00001,
      ST_LISTEN = 5'b00010,
      ST_PAUSE  = 5'b00100,
      ST_WARN   = 5'b01000,
      ST_ERROR  = 5'b10000
   } ctrl_state_type;

   function automatic logic [MODE_W-1:0] mode_code(ctrl_state_type st);
      logic [MODE_W-1:0] code;
      case (st)
         ST_WAIT:   code = MODE_WAIT;
         ST_LISTEN: code = MODE_LISTEN;
         ST_PAUSE:  code = MODE_PAUSE;
         ST_WARN:   code = MODE_WARN;
         default:   code = MODE_ERROR;
      endcase
      return code;
   endfunction

endpackage

[rtl/sensor_level_monitor.sv]
// ----------------------------------------------------------------------------
// Sensor level monitor
// Button driven control, sample filtering, millivolt scaling, level alarms.
// ----------------------------------------------------------------------------
// One item is accepted per cycle while the pipe is not stalled, and its result
// passes the control stage, filter stage and output register in turn; the
// rate is set by the control state, tick counter and window sum, which are
// updated at the accepting edge. The moving average window lives in
// a WINDOW-entry memory written in order; a wrap flag masks entries not yet
// written, so no clearing pass is needed after reset or restart. The whole
// pipe stalls while a result waits on rsp_ready, and neither input channel is
// ready during reset.
module sensor_level_monitor #(
   parameter int WINDOW = slm_pkg::WINDOW_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [slm_pkg::ACTION_W-1:0]        req_action,
   input  logic                                req_button_level,
   input  logic [slm_pkg::SAMPLE_W-1:0]        req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [slm_pkg::MODE_W-1:0]          rsp_mode_state,
   output logic [slm_pkg::SAMPLE_W-1:0]        rsp_filtered_value,
   output logic [slm_pkg::SAMPLE_W-1:0]        rsp_millivolts,
   output logic                                rsp_sample_used,
   output logic                                rsp_restart,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [slm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [slm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int AW      = $clog2(WINDOW);
   localparam int SUM_W   = slm_pkg::SAMPLE_W + $clog2(WINDOW);
   localparam int TH_W    = SUM_W + 1;
   localparam int MUL_W   = SUM_W + 1;
   localparam int PROD_W  = SUM_W + MUL_W;
   localparam int AVG_SHIFT = SUM_W + $clog2(WINDOW);
   // sum / WINDOW == (sum * AVG_MUL) >> AVG_SHIFT over the whole sum range
   localparam logic [MUL_W-1:0] AVG_MUL =
      MUL_W'(((64'd1 << AVG_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
   localparam logic [AW-1:0] WP_LAST = AW'(WINDOW - 1);
   localparam logic [TH_W-1:0] WARN_TH_RST =
      (TH_W'(slm_pkg::WARN_LEVEL_RST) + TH_W'(1)) * TH_W'(WINDOW);
   localparam logic [TH_W-1:0] ERROR_TH_RST =
      (TH_W'(slm_pkg::ERROR_LEVEL_RST) + TH_W'(1)) * TH_W'(WINDOW);

   // configuration
   logic [1:0]                          filter_mode_ff;
   logic [slm_pkg::SAMPLE_W-1:0]        warn_level_ff;
   logic [slm_pkg::SAMPLE_W-1:0]        error_level_ff;
   logic [slm_pkg::DWELL_W-1:0]         dwell_ms_ff;
   logic signed [slm_pkg::OFFSET_W-1:0] noise_offset_ff;
   logic [TH_W-1:0]                     warn_th_ff;
   logic [TH_W-1:0]                     error_th_ff;
   logic [TH_W-1:0]                     csr_th;

   // block state
   slm_pkg::ctrl_state_type      state_ff, state_in;
   logic                         last_btn_ff, last_btn_in;
   logic [slm_pkg::TIME_W-1:0]   now_ff, now_in;
   logic [slm_pkg::TIME_W-1:0]   dwell_start_ff, dwell_start_in;
   logic                         armed_ff, armed_in;
   logic [SUM_W-1:0]             sum_ff, sum_in;
   logic [AW-1:0]                wp_ff, wp_in;
   logic                         wrapped_ff, wrapped_in;

   // window memory
   logic [slm_pkg::SAMPLE_W-1:0] win_mem [WINDOW];
   logic [slm_pkg::SAMPLE_W-1:0] win_rd_ff;
   logic                         mem_we;

   // stage 1
   logic                         v1_ff;
   logic [slm_pkg::MODE_W-1:0]   s1_mode_ff;
   logic                         s1_used_ff, s1_restart_ff, s1_avg_ff;
   logic [SUM_W-1:0]             s1_sum_ff;
   logic [slm_pkg::SAMPLE_W-1:0] s1_direct_ff;

   // stage 2
   logic                         v2_ff;
   logic [slm_pkg::MODE_W-1:0]   s2_mode_ff;
   logic                         s2_used_ff, s2_restart_ff;
   logic [slm_pkg::SAMPLE_W-1:0] s2_f_ff, s2_f_in;

   // output register
   logic                         rsp_valid_ff;
   logic [slm_pkg::MODE_W-1:0]   rsp_mode_ff;
   logic [slm_pkg::SAMPLE_W-1:0] rsp_f_ff, rsp_mv_ff;
   logic                         rsp_used_ff, rsp_restart_ff;

   logic                         adv, req_accept;
   logic                         used, restart, avg_mode;
   logic [slm_pkg::SAMPLE_W-1:0] old_val, direct_val;
   logic signed [slm_pkg::SAMPLE_W+1:0] off_sum;
   logic [SUM_W-1:0]             avg_sum;
   logic                         gt_err, gt_warn;
   logic [slm_pkg::TIME_W-1:0]   elapsed;
   logic [PROD_W-1:0]            avg_prod;
   logic [slm_pkg::MV_PROD_W-1:0] mv_prod;

   assign adv        = !rsp_valid_ff || rsp_ready;
   assign req_ready  = adv && !reset;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = !reset;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mode_state     = rsp_mode_ff;
   assign rsp_filtered_value = rsp_f_ff;
   assign rsp_millivolts     = rsp_mv_ff;
   assign rsp_sample_used    = rsp_used_ff;
   assign rsp_restart        = rsp_restart_ff;

   // ---------------- configuration ----------------
   assign csr_th = (TH_W'(csr_wdata[slm_pkg::SAMPLE_W-1:0]) + TH_W'(1)) * TH_W'(WINDOW);

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_mode_ff  <= slm_pkg::FILTER_MODE_RST;
         warn_level_ff   <= slm_pkg::WARN_LEVEL_RST;
         error_level_ff  <= slm_pkg::ERROR_LEVEL_RST;
         dwell_ms_ff     <= slm_pkg::DWELL_MS_RST;
         noise_offset_ff <= slm_pkg::NOISE_OFFSET_RST;
         warn_th_ff      <= WARN_TH_RST;
         error_th_ff     <= ERROR_TH_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            slm_pkg::CSR_FILTER_MODE: begin
               filter_mode_ff <= csr_wdata[1:0];
            end
            slm_pkg::CSR_WARN_LEVEL: begin
               warn_level_ff <= csr_wdata[slm_pkg::SAMPLE_W-1:0];
               warn_th_ff    <= csr_th;
            end
            slm_pkg::CSR_ERROR_LEVEL: begin
               error_level_ff <= csr_wdata[slm_pkg::SAMPLE_W-1:0];
               error_th_ff    <= csr_th;
            end
            slm_pkg::CSR_DWELL_MS: begin
               dwell_ms_ff <= csr_wdata[slm_pkg::DWELL_W-1:0];
            end
            slm_pkg::CSR_NOISE_OFFSET: begin
               noise_offset_ff <= csr_wdata[slm_pkg::OFFSET_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------- stage 1: control and window ----------------
   assign avg_mode = (filter_mode_ff == slm_pkg::FILT_AVG);
   assign old_val  = wrapped_ff ? win_rd_ff : '0;
   assign avg_sum  = sum_ff - SUM_W'(old_val) + SUM_W'(req_sample);
   assign off_sum  = $signed({2'b00, req_sample}) +
                     $signed({noise_offset_ff[slm_pkg::OFFSET_W-1], noise_offset_ff});
   assign elapsed  = now_ff - dwell_start_ff;

   always_comb begin
      if (filter_mode_ff == slm_pkg::FILT_OFFSET) begin
         if (off_sum[slm_pkg::SAMPLE_W+1]) begin
            direct_val = '0;
         end else if (off_sum[slm_pkg::SAMPLE_W]) begin
            direct_val = slm_pkg::SAMPLE_MAX;
         end else begin
            direct_val = off_sum[slm_pkg::SAMPLE_W-1:0];
         end
      end else begin
         direct_val = req_sample;
      end
   end

   always_comb begin
      if (avg_mode) begin
         gt_err  = {1'b0, avg_sum} >= error_th_ff;
         gt_warn = {1'b0, avg_sum} >= warn_th_ff;
      end else begin
         gt_err  = direct_val > error_level_ff;
         gt_warn = direct_val > warn_level_ff;
      end
   end

   always_comb begin
      state_in       = state_ff;
      last_btn_in    = last_btn_ff;
      now_in         = now_ff;
      dwell_start_in = dwell_start_ff;
      armed_in       = armed_ff;
      sum_in         = sum_ff;
      wp_in          = wp_ff;
      wrapped_in     = wrapped_ff;
      mem_we         = 1'b0;
      used           = 1'b0;
      restart        = 1'b0;
      if (req_accept) begin
         case (req_action)
            slm_pkg::ACT_TICK: begin
               now_in = now_ff + 1'b1;
            end
            slm_pkg::ACT_BUTTON: begin
               if (last_btn_ff && !req_button_level) begin
                  case (state_ff)
                     slm_pkg::ST_WAIT:   state_in = slm_pkg::ST_LISTEN;
                     slm_pkg::ST_LISTEN: state_in = slm_pkg::ST_PAUSE;
                     slm_pkg::ST_PAUSE:  state_in = slm_pkg::ST_LISTEN;
                     slm_pkg::ST_WARN:   state_in = slm_pkg::ST_WAIT;
                     default:            restart  = 1'b1;
                  endcase
               end
               if (restart) begin
                  state_in       = slm_pkg::ST_WAIT;
                  last_btn_in    = 1'b1;
                  now_in         = '0;
                  dwell_start_in = '0;
                  armed_in       = 1'b0;
                  sum_in         = '0;
                  wp_in          = '0;
                  wrapped_in     = 1'b0;
               end else begin
                  last_btn_in = req_button_level;
               end
            end
            slm_pkg::ACT_SAMPLE: begin
               if (state_ff == slm_pkg::ST_LISTEN) begin
                  used = 1'b1;
                  if (avg_mode) begin
                     mem_we = 1'b1;
                     sum_in = avg_sum;
                     if (wp_ff == WP_LAST) begin
                        wp_in      = '0;
                        wrapped_in = 1'b1;
                     end else begin
                        wp_in = wp_ff + 1'b1;
                     end
                  end
                  if (gt_err) begin
                     state_in = slm_pkg::ST_ERROR;
                  end else if (gt_warn) begin
                     if (!armed_ff) begin
                        armed_in       = 1'b1;
                        dwell_start_in = now_ff;
                     end else if (elapsed >= slm_pkg::TIME_W'(dwell_ms_ff)) begin
                        state_in = slm_pkg::ST_WARN;
                        armed_in = 1'b0;
                     end
                  end else begin
                     armed_in = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         win_mem[wp_ff] <= req_sample;
      end
      win_rd_ff <= win_mem[wp_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= slm_pkg::ST_WAIT;
         last_btn_ff    <= 1'b1;
         now_ff         <= '0;
         dwell_start_ff <= '0;
         armed_ff       <= 1'b0;
         sum_ff         <= '0;
         wp_ff          <= '0;
         wrapped_ff     <= 1'b0;
      end else begin
         state_ff       <= state_in;
         last_btn_ff    <= last_btn_in;
         now_ff         <= now_in;
         dwell_start_ff <= dwell_start_in;
         armed_ff       <= armed_in;
         sum_ff         <= sum_in;
         wp_ff          <= wp_in;
         wrapped_ff     <= wrapped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_mode_ff    <= slm_pkg::mode_code(state_in);
         s1_used_ff    <= used;
         s1_restart_ff <= restart;
         s1_avg_ff     <= avg_mode;
         s1_sum_ff     <= avg_sum;
         s1_direct_ff  <= direct_val;
      end
   end

   // ---------------- stage 2: filtered value, held between samples ----------------
   assign avg_prod = PROD_W'(s1_sum_ff) * PROD_W'(AVG_MUL);

   always_comb begin
      if (s1_restart_ff) begin
         s2_f_in = '0;
      end else if (s1_used_ff) begin
         s2_f_in = s1_avg_ff ? avg_prod[AVG_SHIFT +: slm_pkg::SAMPLE_W] : s1_direct_ff;
      end else begin
         s2_f_in = s2_f_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && v1_ff) begin
         s2_mode_ff    <= s1_mode_ff;
         s2_used_ff    <= s1_used_ff;
         s2_restart_ff <= s1_restart_ff;
      end
   end

   // ---------------- stage 3: millivolts and output register ----------------
   assign mv_prod = slm_pkg::MV_PROD_W'(s2_f_ff) * slm_pkg::MV_PROD_W'(slm_pkg::MV_MUL);

   always_ff @(posedge clock) begin
      if (adv && v2_ff) begin
         rsp_mode_ff    <= s2_mode_ff;
         rsp_f_ff       <= s2_f_ff;
         rsp_mv_ff      <= mv_prod[slm_pkg::MV_SHIFT +: slm_pkg::SAMPLE_W];
         rsp_used_ff    <= s2_used_ff;
         rsp_restart_ff <= s2_restart_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         s2_f_ff      <= '0;
      end else if (adv) begin
         v1_ff        <= req_accept;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= v2_ff;
         if (v1_ff) begin
            s2_f_ff <= s2_f_in;
         end
      end
   end

   // ---------------- assertions ----------------
   a_wp_range : assert property (@(posedge clock) disable iff (reset)
      wp_ff <= WP_LAST)
      else $error("window write position out of range");

   a_restart_clears : assert property (@(posedge clock) disable iff (reset)
      restart |=> (state_ff == slm_pkg::ST_WAIT) && (sum_ff == '0) && (wp_ff == '0) &&
                  !wrapped_ff && !armed_ff && (now_ff == '0))
      else $error("restart left state behind");

   a_restart_result : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_restart |-> (rsp_mode_state == slm_pkg::MODE_WAIT) &&
                                   (rsp_filtered_value == '0) && (rsp_millivolts == '0))
      else $error("restart item carries stale values");

   a_mv_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_millivolts <= slm_pkg::MV_MAX)
      else $error("millivolts out of range");

   a_used_listen : assert property (@(posedge clock) disable iff (reset)
      used |-> state_ff == slm_pkg::ST_LISTEN)
      else $error("sample processed outside listening");

endmodule

[verif/sensor_level_monitor_tb.sv]
// ----------------------------------------------------------------------------
// Sensor level monitor testbench
// Drives tick, button and sample items through the monitor with random gaps
// on both channels and checks every result against an in-bench tracker of
// the control state, filters, dwell timer and restarts, or a typed row's own
// want. A directed table runs first, then random phases with varied registers.
// ----------------------------------------------------------------------------
module sensor_level_monitor_tb;

   localparam int WINDOW_LEN = slm_pkg::WINDOW_DEF;
   localparam logic [slm_pkg::ACTION_W-1:0]  ACT_SPARE  = 2'd3;
   localparam logic [1:0]                    FILT_SPARE = 2'd3;
   localparam logic [slm_pkg::CSR_IDX_W-1:0] CSR_SPARE  = 3'd7;

   typedef struct packed {
      logic [slm_pkg::MODE_W-1:0]   mode;
      logic [slm_pkg::SAMPLE_W-1:0] value;
      logic [slm_pkg::SAMPLE_W-1:0] mv;
      logic                         used;
      logic                         restart;
   } level_result_type;

   typedef enum logic {ROW_ITEM, ROW_REG} row_kind_type;

   typedef struct packed {
      row_kind_type                   kind;
      logic [slm_pkg::CSR_IDX_W-1:0]  idx;
      logic [slm_pkg::CSR_DATA_W-1:0] data;
      logic [slm_pkg::ACTION_W-1:0]   action;
      logic                           level;
      logic [slm_pkg::SAMPLE_W-1:0]   sample;
      logic                           typed;
      level_result_type               want;
   } stim_row_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [slm_pkg::ACTION_W-1:0]   req_action = slm_pkg::ACT_TICK;
   logic                           req_button_level = 1'b1;
   logic [slm_pkg::SAMPLE_W-1:0]   req_sample = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [slm_pkg::MODE_W-1:0]     rsp_mode_state;
   logic [slm_pkg::SAMPLE_W-1:0]   rsp_filtered_value;
   logic [slm_pkg::SAMPLE_W-1:0]   rsp_millivolts;
   logic                           rsp_sample_used;
   logic                           rsp_restart;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [slm_pkg::CSR_IDX_W-1:0]  csr_index = slm_pkg::CSR_FILTER_MODE;
   logic [slm_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   sensor_level_monitor uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_button_level   (req_button_level),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_mode_state     (rsp_mode_state),
      .rsp_filtered_value (rsp_filtered_value),
      .rsp_millivolts     (rsp_millivolts),
      .rsp_sample_used    (rsp_sample_used),
      .rsp_restart        (rsp_restart),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #5 clock = ~clock;

   // tracker copy of registers and state
   logic [1:0]                          cfg_mode;
   logic [slm_pkg::SAMPLE_W-1:0]        cfg_warn;
   logic [slm_pkg::SAMPLE_W-1:0]        cfg_error;
   logic [slm_pkg::DWELL_W-1:0]         cfg_dwell;
   logic signed [slm_pkg::OFFSET_W-1:0] cfg_offset;

   logic [slm_pkg::SAMPLE_W-1:0] win_store [WINDOW_LEN];
   logic [19:0]                  win_sum;
   int                           win_pos;
   logic [slm_pkg::MODE_W-1:0]   ctrl_now;
   logic                         last_level;
   logic [slm_pkg::TIME_W-1:0]   now_ms;
   logic [slm_pkg::TIME_W-1:0]   dwell_from;
   logic                         dwell_armed;
   logic [slm_pkg::SAMPLE_W-1:0] held_value;
   logic [slm_pkg::SAMPLE_W-1:0] held_mv;

   level_result_type expected_readings [$];
   stim_row_type     directed_rows [35];

   bit steady = 1'b0;
   int fail_count = 0;
   int results_checked = 0;
   int items_sent = 0;
   int reg_writes = 0;
   int restarts_seen = 0;
   int warn_entries = 0;
   int error_entries = 0;

   function automatic void clear_monitor();
      foreach (win_store[i]) win_store[i] = '0;
      win_sum     = '0;
      win_pos     = 0;
      ctrl_now    = slm_pkg::MODE_WAIT;
      last_level  = 1'b1;
      now_ms      = '0;
      dwell_from  = '0;
      dwell_armed = 1'b0;
      held_value  = '0;
      held_mv     = '0;
   endfunction

   function automatic level_result_type predict_levels(logic [slm_pkg::ACTION_W-1:0] act,
                                                       logic lvl,
                                                       logic [slm_pkg::SAMPLE_W-1:0] smp);
      level_result_type             res;
      logic [slm_pkg::SAMPLE_W-1:0] filt;
      int                           adj;
      res.used    = 1'b0;
      res.restart = 1'b0;
      case (act)
         slm_pkg::ACT_TICK: now_ms = now_ms + 32'd1;
         slm_pkg::ACT_BUTTON: begin
            if (last_level && !lvl) begin
               case (ctrl_now)
                  slm_pkg::MODE_WAIT:   ctrl_now = slm_pkg::MODE_LISTEN;
                  slm_pkg::MODE_LISTEN: ctrl_now = slm_pkg::MODE_PAUSE;
                  slm_pkg::MODE_PAUSE:  ctrl_now = slm_pkg::MODE_LISTEN;
                  slm_pkg::MODE_WARN:   ctrl_now = slm_pkg::MODE_WAIT;
                  default: begin
                     clear_monitor();
                     res.restart = 1'b1;
                     restarts_seen++;
                  end
               endcase
            end
            if (!res.restart) last_level = lvl;
         end
         slm_pkg::ACT_SAMPLE: begin
            if (ctrl_now == slm_pkg::MODE_LISTEN) begin
               res.used = 1'b1;
               case (cfg_mode)
                  slm_pkg::FILT_AVG: begin
                     win_sum = win_sum - win_store[win_pos] + smp;
                     win_store[win_pos] = smp;
                     win_pos = (win_pos + 1) % WINDOW_LEN;
                     filt = slm_pkg::SAMPLE_W'(win_sum / WINDOW_LEN);
                  end
                  slm_pkg::FILT_OFFSET: begin
                     adj = int'(smp) + int'(cfg_offset);
                     if (adj < 0) adj = 0;
                     if (adj > int'(slm_pkg::SAMPLE_MAX)) adj = int'(slm_pkg::SAMPLE_MAX);
                     filt = slm_pkg::SAMPLE_W'(adj);
                  end
                  default: filt = smp;
               endcase
               held_value = filt;
               held_mv = slm_pkg::SAMPLE_W'((int'(filt) * int'(slm_pkg::MV_MAX)) /
                                            int'(slm_pkg::SAMPLE_MAX));
               if (filt > cfg_error) begin
                  ctrl_now = slm_pkg::MODE_ERROR;
                  error_entries++;
               end else if (filt > cfg_warn) begin
                  if (!dwell_armed) begin
                     dwell_armed = 1'b1;
                     dwell_from  = now_ms;
                  end else if (now_ms - dwell_from >= slm_pkg::TIME_W'(cfg_dwell)) begin
                     ctrl_now    = slm_pkg::MODE_WARN;
                     dwell_armed = 1'b0;
                     warn_entries++;
                  end
               end else begin
                  dwell_armed = 1'b0;
               end
            end
         end
         default: ;
      endcase
      res.mode  = ctrl_now;
      res.value = held_value;
      res.mv    = held_mv;
      return res;
   endfunction

   function automatic stim_row_type item_row(logic [slm_pkg::ACTION_W-1:0] act, logic lvl,
                                             logic [slm_pkg::SAMPLE_W-1:0] smp);
      stim_row_type row;
      row        = '0;
      row.kind   = ROW_ITEM;
      row.action = act;
      row.level  = lvl;
      row.sample = smp;
      return row;
   endfunction

   function automatic stim_row_type typed_row(logic [slm_pkg::ACTION_W-1:0] act, logic lvl,
                                              logic [slm_pkg::SAMPLE_W-1:0] smp,
                                              logic [slm_pkg::MODE_W-1:0] mode,
                                              logic [slm_pkg::SAMPLE_W-1:0] value,
                                              logic [slm_pkg::SAMPLE_W-1:0] mv,
                                              logic used, logic rst);
      stim_row_type row;
      row       = item_row(act, lvl, smp);
      row.typed = 1'b1;
      row.want  = '{mode, value, mv, used, rst};
      return row;
   endfunction

   function automatic stim_row_type reg_row(logic [slm_pkg::CSR_IDX_W-1:0] idx,
                                            logic [slm_pkg::CSR_DATA_W-1:0] data);
      stim_row_type row;
      row      = '0;
      row.kind = ROW_REG;
      row.idx  = idx;
      row.data = data;
      return row;
   endfunction

   // called at a rising edge; returns at the edge the item is taken
   task automatic send_item(input logic [slm_pkg::ACTION_W-1:0] act, input logic lvl,
                            input logic [slm_pkg::SAMPLE_W-1:0] smp, input logic typed,
                            input level_result_type want);
      level_result_type res;
      while (!steady && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= act;
      req_button_level <= lvl;
      req_sample       <= smp;
      do @(posedge clock); while (!req_ready);
      res = predict_levels(act, lvl, smp);
      expected_readings.push_back(typed ? want : res);
      items_sent++;
   endtask

   // leaves csr_valid high; the caller lowers it after the last write
   task automatic write_reg(input logic [slm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [slm_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         slm_pkg::CSR_FILTER_MODE:  cfg_mode   = data[1:0];
         slm_pkg::CSR_WARN_LEVEL:   cfg_warn   = data[slm_pkg::SAMPLE_W-1:0];
         slm_pkg::CSR_ERROR_LEVEL:  cfg_error  = data[slm_pkg::SAMPLE_W-1:0];
         slm_pkg::CSR_DWELL_MS:     cfg_dwell  = data[slm_pkg::DWELL_W-1:0];
         slm_pkg::CSR_NOISE_OFFSET: cfg_offset = data[slm_pkg::OFFSET_W-1:0];
         default: ;
      endcase
      reg_writes++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic press_button();
      send_item(slm_pkg::ACT_BUTTON, 1'b1, slm_pkg::SAMPLE_W'($urandom), 1'b0, '0);
      send_item(slm_pkg::ACT_BUTTON, 1'b0, slm_pkg::SAMPLE_W'($urandom), 1'b0, '0);
   endtask

   task automatic random_items(input int count, input bit long_window);
      int made;
      int press_odds;
      int pick;
      int burst;
      int v;
      made = 0;
      while (made < count) begin
         press_odds = (ctrl_now == slm_pkg::MODE_LISTEN) ? (long_window ? 1 : 4) : 40;
         if ($urandom_range(99) < press_odds) begin
            press_button();
            made += 2;
         end else begin
            pick = $urandom_range(99);
            if (pick < 5) begin
               send_item(ACT_SPARE, 1'($urandom), slm_pkg::SAMPLE_W'($urandom), 1'b0, '0);
            end else if (pick < 10) begin
               send_item(slm_pkg::ACT_BUTTON, 1'($urandom), slm_pkg::SAMPLE_W'($urandom),
                         1'b0, '0);
               made++;
            end else if (pick < 35) begin
               burst = $urandom_range(4, 1);
               repeat (burst)
                  send_item(slm_pkg::ACT_TICK, 1'($urandom), slm_pkg::SAMPLE_W'($urandom),
                            1'b0, '0);
               made += burst;
            end else begin
               // aim near the levels so the dwell and alarm edges get hit
               case ($urandom_range(3))
                  0: v = int'(cfg_warn) + int'($urandom_range(8)) - 4;
                  1: v = int'(cfg_error) + int'($urandom_range(8)) - 4;
                  2: v = $urandom_range(1) ? int'(slm_pkg::SAMPLE_MAX) : 0;
                  default: v = int'($urandom_range(4095));
               endcase
               if (cfg_mode == slm_pkg::FILT_OFFSET && $urandom_range(1))
                  v = v - int'(cfg_offset);
               if (long_window && $urandom_range(99) < 60) v = int'($urandom_range(4095, 3000));
               if (v < 0) v = 0;
               if (v > int'(slm_pkg::SAMPLE_MAX)) v = int'(slm_pkg::SAMPLE_MAX);
               send_item(slm_pkg::ACT_SAMPLE, 1'($urandom), slm_pkg::SAMPLE_W'(v), 1'b0, '0);
               made++;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (steady) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(99) >= 14);
   end

   always @(posedge clock) begin
      level_result_type got;
      level_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         got = {rsp_mode_state, rsp_filtered_value, rsp_millivolts, rsp_sample_used,
                rsp_restart};
         if (expected_readings.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result: mode %0d value %0d mv %0d used %b restart %b",
                        got.mode, got.value, got.mv, got.used, got.restart);
         end else begin
            want = expected_readings.pop_front();
            results_checked++;
            if (got.mode !== want.mode || got.value !== want.value || got.mv !== want.mv ||
                got.used !== want.used || got.restart !== want.restart) begin
               fail_count++;
               if (fail_count <= 10)
                  $display({"result %0d mismatch: exp mode %0d value %0d mv %0d used %b ",
                            "restart %b, got mode %0d value %0d mv %0d used %b restart %b"},
                           results_checked, want.mode, want.value, want.mv, want.used,
                           want.restart, got.mode, got.value, got.mv, got.used, got.restart);
            end
         end
      end
   end

   initial begin
      bit                             prev_reg;
      logic [1:0]                     p_mode;
      logic [slm_pkg::SAMPLE_W-1:0]   p_warn;
      logic [slm_pkg::SAMPLE_W-1:0]   p_error;
      logic [slm_pkg::DWELL_W-1:0]    p_dwell;
      logic [slm_pkg::OFFSET_W-1:0]   p_offset;
      logic [slm_pkg::CSR_DATA_W-1:0] pad;

      cfg_mode   = slm_pkg::FILTER_MODE_RST;
      cfg_warn   = slm_pkg::WARN_LEVEL_RST;
      cfg_error  = slm_pkg::ERROR_LEVEL_RST;
      cfg_dwell  = slm_pkg::DWELL_MS_RST;
      cfg_offset = slm_pkg::NOISE_OFFSET_RST;
      clear_monitor();

      directed_rows = '{
         typed_row(slm_pkg::ACT_TICK,   1'b1, 12'd0,    slm_pkg::MODE_WAIT,
                   '0, '0, 1'b0, 1'b0),
         typed_row(slm_pkg::ACT_SAMPLE, 1'b1, 12'd4095, slm_pkg::MODE_WAIT,
                   '0, '0, 1'b0, 1'b0),
         typed_row(slm_pkg::ACT_BUTTON, 1'b0, 12'd0,    slm_pkg::MODE_LISTEN,
                   '0, '0, 1'b0, 1'b0),
         item_row (slm_pkg::ACT_SAMPLE, 1'b0, 12'd0),
         typed_row(slm_pkg::ACT_SAMPLE, 1'b1, 12'd4095, slm_pkg::MODE_ERROR,
                   slm_pkg::SAMPLE_MAX, slm_pkg::MV_MAX, 1'b1, 1'b0),
         typed_row(ACT_SPARE,           1'b1, 12'd4095, slm_pkg::MODE_ERROR,
                   slm_pkg::SAMPLE_MAX, slm_pkg::MV_MAX, 1'b0, 1'b0),
         typed_row(slm_pkg::ACT_BUTTON, 1'b1, 12'd0,    slm_pkg::MODE_ERROR,
                   slm_pkg::SAMPLE_MAX, slm_pkg::MV_MAX, 1'b0, 1'b0),
         // press in error restarts; the next low level counts as a fresh press
         typed_row(slm_pkg::ACT_BUTTON, 1'b0, 12'd0,    slm_pkg::MODE_WAIT,
                   '0, '0, 1'b0, 1'b1),
         typed_row(slm_pkg::ACT_BUTTON, 1'b0, 12'd0,    slm_pkg::MODE_LISTEN,
                   '0, '0, 1'b0, 1'b0),
         reg_row(slm_pkg::CSR_NOISE_OFFSET, 16'hF001),
         reg_row(slm_pkg::CSR_WARN_LEVEL,   16'd100),
         reg_row(slm_pkg::CSR_DWELL_MS,     16'd2),
         reg_row(CSR_SPARE,                 16'hFFFF),
         typed_row(slm_pkg::ACT_SAMPLE, 1'b1, 12'd4095, slm_pkg::MODE_LISTEN,
                   '0, '0, 1'b1, 1'b0),
         reg_row(slm_pkg::CSR_FILTER_MODE, 16'(FILT_SPARE)),
         item_row(slm_pkg::ACT_SAMPLE, 1'b1, 12'd101),
         item_row(slm_pkg::ACT_TICK,   1'b1, 12'd0),
         item_row(slm_pkg::ACT_SAMPLE, 1'b1, 12'd200),
         item_row(slm_pkg::ACT_TICK,   1'b1, 12'd0),
         item_row(slm_pkg::ACT_SAMPLE, 1'b1, 12'd150),
         item_row(slm_pkg::ACT_BUTTON, 1'b1, 12'd0),
         item_row(slm_pkg::ACT_BUTTON, 1'b0, 12'd0),
         item_row(slm_pkg::ACT_BUTTON, 1'b1, 12'd0),
         item_row(slm_pkg::ACT_BUTTON, 1'b0, 12'd0),
         item_row(slm_pkg::ACT_BUTTON, 1'b1, 12'd0),
         item_row(slm_pkg::ACT_BUTTON, 1'b0, 12'd0),
         item_row(slm_pkg::ACT_SAMPLE, 1'b1, 12'd4095),
         item_row(slm_pkg::ACT_BUTTON, 1'b1, 12'd0),
         item_row(slm_pkg::ACT_BUTTON, 1'b0, 12'd0),
         reg_row(slm_pkg::CSR_FILTER_MODE, 16'(slm_pkg::FILT_AVG)),
         reg_row(slm_pkg::CSR_ERROR_LEVEL, 16'd4095),
         reg_row(slm_pkg::CSR_WARN_LEVEL,  16'd0),
         reg_row(slm_pkg::CSR_DWELL_MS,    16'd0),
         item_row(slm_pkg::ACT_SAMPLE, 1'b1, 12'd4095),
         item_row(slm_pkg::ACT_SAMPLE, 1'b1, 12'd4095)
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      prev_reg = 1'b0;
      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_REG) begin
            if (!prev_reg) drain();
            write_reg(directed_rows[r].idx, directed_rows[r].data);
            prev_reg = 1'b1;
         end else begin
            if (prev_reg) csr_valid <= 1'b0;
            send_item(directed_rows[r].action, directed_rows[r].level, directed_rows[r].sample,
                      directed_rows[r].typed, directed_rows[r].want);
            prev_reg = 1'b0;
         end
      end

      for (int ph = 0; ph < 8; ph++) begin
         drain();
         case (ph)
            0: begin
               p_mode = slm_pkg::FILT_RAW; p_warn = '0; p_error = '0; p_dwell = '0;
               p_offset = 13'h1001;
            end
            1: begin
               p_mode = slm_pkg::FILT_AVG; p_warn = 12'($urandom_range(2600, 2000));
               p_error = slm_pkg::SAMPLE_MAX; p_dwell = 16'($urandom_range(20));
               p_offset = 13'($urandom);
            end
            2: begin
               p_mode = FILT_SPARE; p_warn = slm_pkg::SAMPLE_MAX; p_error = slm_pkg::SAMPLE_MAX;
               p_dwell = 16'hFFFF; p_offset = 13'd4095;
            end
            default: begin
               p_mode = 2'($urandom_range(3));
               p_warn = 12'($urandom_range(4095));
               p_error = 12'($urandom_range(4095, int'(p_warn)));
               p_dwell = 16'($urandom_range(30));
               p_offset = 13'(int'($urandom_range(8190)) - 4095);
            end
         endcase
         // spare high bits of the write data must be ignored
         pad = 16'($urandom);
         write_reg(slm_pkg::CSR_FILTER_MODE,  {pad[15:2], p_mode});
         pad = 16'($urandom);
         write_reg(slm_pkg::CSR_WARN_LEVEL,   {pad[15:12], p_warn});
         pad = 16'($urandom);
         write_reg(slm_pkg::CSR_ERROR_LEVEL,  {pad[15:12], p_error});
         write_reg(slm_pkg::CSR_DWELL_MS,     p_dwell);
         pad = 16'($urandom);
         write_reg(slm_pkg::CSR_NOISE_OFFSET, {pad[15:13], p_offset});
         csr_valid <= 1'b0;
         steady = (ph == 3);
         random_items((ph == 1) ? 320 : 70, ph == 1);
         steady = 1'b0;
      end

      drain();
      $display("Checked %0d results from %0d items, %0d register writes, directed then random.",
               results_checked, items_sent, reg_writes);
      $display("Tracker saw %0d restarts, %0d warning entries, %0d error entries.",
               restarts_seen, warn_entries, error_entries);
      if (fail_count == 0 && expected_readings.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("FAIL");
      $finish;
   end

endmodule
